@@ rtl/core/arp_pkg.sv @@
// ----------------------------------------------------------------------------
// arp_pkg
// Types, constants and defaults shared by the ARP request responder modules.
// ----------------------------------------------------------------------------
package arp_pkg;

  // Default for the saturating frame byte counter.
  localparam int MAX_FRAME_BYTES_DEF = 2047;

  // Reply frame length and the width of an index into it.
  localparam int REPLY_LEN = 42;
  localparam int REPLY_IDX_W = $clog2(REPLY_LEN);

  // Depth of the descriptor queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Protocol constants.
  localparam logic [15:0] ETH_TYPE_ARP   = 16'h0806;
  localparam logic [15:0] ETH_TYPE_IPV4  = 16'h0800;
  localparam logic [15:0] ARP_HW_ETHER   = 16'h0001;
  localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;
  localparam logic [15:0] ARP_OP_REPLY   = 16'h0002;
  localparam logic [7:0]  ARP_HW_LEN     = 8'd6;
  localparam logic [7:0]  ARP_PROTO_LEN  = 8'd4;
  // Upper five bytes of the MAC we answer with; the low byte is the low byte of the target IP.
  localparam logic [39:0] REPLY_MAC_PREFIX = 40'h52_54_00_12_35;

  // Configuration register indexes and reset values.
  typedef enum logic [2:0] {
    CFG_NET_ADDR    = 3'd0,
    CFG_NET_MASK    = 3'd1,
    CFG_DNS_HOST    = 3'd2,
    CFG_ALIAS_HOST  = 3'd3,
    CFG_SERVICE_MAP = 3'd4
  } cfg_reg_t;

  localparam logic [31:0] NET_ADDR_RST   = 32'h0A00_0200;
  localparam logic [31:0] NET_MASK_RST   = 32'hFFFF_FF00;
  localparam logic [7:0]  DNS_HOST_RST   = 8'd3;
  localparam logic [7:0]  ALIAS_HOST_RST = 8'd2;

  typedef struct packed {
    logic [31:0] net_addr;
    logic [31:0] net_mask;
    logic [7:0]  dns_host;
    logic [7:0]  alias_host;
    logic [63:0] service_host_map;
  } cfg_t;

  // Everything the back end needs to build one reply.
  typedef struct packed {
    logic [47:0] frame_src_mac;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
  } reply_desc_t;

endpackage

@@ rtl/core/arp_front.sv @@
// ----------------------------------------------------------------------------
// arp_front
// Frame parser: captures header fields by byte position and, on the last byte
// of a qualifying ARP request, pushes a reply descriptor into the queue.
// ----------------------------------------------------------------------------
module arp_front
  import arp_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  input  logic        q_full,
  output logic        q_push,
  output reply_desc_t q_desc
);

  localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

  logic [CW-1:0] byte_count_r, byte_count_nxt;
  logic [47:0]   frame_src_mac_r, frame_src_mac_nxt;
  logic [15:0]   frame_type_r, frame_type_nxt;
  logic [15:0]   arp_opcode_r, arp_opcode_nxt;
  logic [47:0]   sender_mac_r, sender_mac_nxt;
  logic [31:0]   sender_ip_r, sender_ip_nxt;
  logic [31:0]   target_ip_r, target_ip_nxt;

  logic        accept;
  logic [31:0] host;
  logic        host_hit;
  logic        is_request;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    frame_src_mac_nxt = frame_src_mac_r;
    frame_type_nxt    = frame_type_r;
    arp_opcode_nxt    = arp_opcode_r;
    sender_mac_nxt    = sender_mac_r;
    sender_ip_nxt     = sender_ip_r;
    target_ip_nxt     = target_ip_r;
    byte_count_nxt    = byte_count_r;
    if (accept) begin
      if (byte_count_r >= CW'(6) && byte_count_r <= CW'(11)) begin
        frame_src_mac_nxt = {frame_src_mac_r[39:0], in_tdata};
      end else if (byte_count_r == CW'(12) || byte_count_r == CW'(13)) begin
        frame_type_nxt = {frame_type_r[7:0], in_tdata};
      end else if (byte_count_r == CW'(20) || byte_count_r == CW'(21)) begin
        arp_opcode_nxt = {arp_opcode_r[7:0], in_tdata};
      end else if (byte_count_r >= CW'(22) && byte_count_r <= CW'(27)) begin
        sender_mac_nxt = {sender_mac_r[39:0], in_tdata};
      end else if (byte_count_r >= CW'(28) && byte_count_r <= CW'(31)) begin
        sender_ip_nxt = {sender_ip_r[23:0], in_tdata};
      end else if (byte_count_r >= CW'(38) && byte_count_r <= CW'(41)) begin
        target_ip_nxt = {target_ip_r[23:0], in_tdata};
      end
      if (in_tlast) begin
        byte_count_nxt = '0;
      end else if (byte_count_r < CW'(MAX_FRAME_BYTES)) begin
        byte_count_nxt = byte_count_r + CW'(1);
      end
    end
  end

  // The decision uses the updated fields, since the final target IP byte may
  // arrive on the very byte that ends the frame.
  always_comb begin
    host       = target_ip_nxt & ~cfg.net_mask;
    host_hit   = (host == {24'd0, cfg.dns_host}) || (host == {24'd0, cfg.alias_host}) ||
                 ((host[31:6] == 26'd0) && cfg.service_host_map[host[5:0]]);
    is_request = (byte_count_r >= CW'(REPLY_LEN - 1)) &&
                 (frame_type_nxt == ETH_TYPE_ARP) &&
                 (arp_opcode_nxt == ARP_OP_REQUEST) &&
                 ((target_ip_nxt & cfg.net_mask) == cfg.net_addr);
  end

  assign q_push = accept && in_tlast && is_request && host_hit;

  always_comb begin
    q_desc.frame_src_mac = frame_src_mac_nxt;
    q_desc.sender_mac    = sender_mac_nxt;
    q_desc.sender_ip     = sender_ip_nxt;
    q_desc.target_ip     = target_ip_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_src_mac_r <= frame_src_mac_nxt;
    frame_type_r    <= frame_type_nxt;
    arp_opcode_r    <= arp_opcode_nxt;
    sender_mac_r    <= sender_mac_nxt;
    sender_ip_r     <= sender_ip_nxt;
    target_ip_r     <= target_ip_nxt;
  end

  a_push_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (in_tlast && accept))
    else $error("reply queued on a byte that does not end a frame");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= CW'(MAX_FRAME_BYTES))
    else $error("frame byte counter exceeded its saturation value");

endmodule

@@ rtl/core/arp_queue.sv @@
// ----------------------------------------------------------------------------
// arp_queue
// Short descriptor queue that lets the parser and the reply serializer stall
// independently.
// ----------------------------------------------------------------------------
module arp_queue
  import arp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  reply_desc_t push_desc,
  output logic        full,
  input  logic        pop,
  output reply_desc_t pop_desc,
  output logic        not_empty
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  reply_desc_t   slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full      = (count_r == CNTW'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_desc  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNTW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("descriptor pushed into a full queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(QUEUE_DEPTH))
    else $error("queue occupancy out of range");

endmodule

@@ rtl/core/arp_back.sv @@
// ----------------------------------------------------------------------------
// arp_back
// Reply serializer: takes one descriptor at a time and emits the 42-byte ARP
// reply through a registered output stage.
// ----------------------------------------------------------------------------
module arp_back
  import arp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  reply_desc_t q_desc,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // [7:0] reply_byte, [55:8] client_mac
  output logic        out_tlast
);

  reply_desc_t            cur_r, cur_nxt;
  logic                   active_r, active_nxt;
  logic [REPLY_IDX_W-1:0] idx_r, idx_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [55:0]            out_tdata_r, out_tdata_nxt;
  logic                   out_tlast_r, out_tlast_nxt;

  logic                   emit;
  logic                   at_end;
  logic [47:0]            src_mac;
  logic [7:0]             reply_byte;

  function automatic logic [7:0] mac_byte(input logic [47:0] mac,
                                          input logic [REPLY_IDX_W-1:0] k);
    logic [7:0] b;
    case (k[2:0])
      3'd0:    b = mac[47:40];
      3'd1:    b = mac[39:32];
      3'd2:    b = mac[31:24];
      3'd3:    b = mac[23:16];
      3'd4:    b = mac[15:8];
      default: b = mac[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [7:0] ip_byte(input logic [31:0] ip,
                                         input logic [REPLY_IDX_W-1:0] k);
    logic [7:0] b;
    case (k[1:0])
      2'd0:    b = ip[31:24];
      2'd1:    b = ip[23:16];
      2'd2:    b = ip[15:8];
      default: b = ip[7:0];
    endcase
    return b;
  endfunction

  assign emit   = active_r && (!out_tvalid_r || out_tready);
  assign at_end = (idx_r == REPLY_IDX_W'(REPLY_LEN - 1));
  // The next descriptor is taken as the current reply sends its last byte.
  assign q_pop  = q_valid && (!active_r || (emit && at_end));

  always_comb begin
    src_mac    = {REPLY_MAC_PREFIX, cur_r.target_ip[7:0]};
    reply_byte = 8'h00;
    if (idx_r inside {[0:5]}) begin
      reply_byte = mac_byte(cur_r.frame_src_mac, idx_r);
    end else if (idx_r inside {[6:11]}) begin
      reply_byte = mac_byte(src_mac, idx_r - REPLY_IDX_W'(6));
    end else if (idx_r == REPLY_IDX_W'(12)) begin
      reply_byte = ETH_TYPE_ARP[15:8];
    end else if (idx_r == REPLY_IDX_W'(13)) begin
      reply_byte = ETH_TYPE_ARP[7:0];
    end else if (idx_r == REPLY_IDX_W'(14)) begin
      reply_byte = ARP_HW_ETHER[15:8];
    end else if (idx_r == REPLY_IDX_W'(15)) begin
      reply_byte = ARP_HW_ETHER[7:0];
    end else if (idx_r == REPLY_IDX_W'(16)) begin
      reply_byte = ETH_TYPE_IPV4[15:8];
    end else if (idx_r == REPLY_IDX_W'(17)) begin
      reply_byte = ETH_TYPE_IPV4[7:0];
    end else if (idx_r == REPLY_IDX_W'(18)) begin
      reply_byte = ARP_HW_LEN;
    end else if (idx_r == REPLY_IDX_W'(19)) begin
      reply_byte = ARP_PROTO_LEN;
    end else if (idx_r == REPLY_IDX_W'(20)) begin
      reply_byte = ARP_OP_REPLY[15:8];
    end else if (idx_r == REPLY_IDX_W'(21)) begin
      reply_byte = ARP_OP_REPLY[7:0];
    end else if (idx_r inside {[22:27]}) begin
      reply_byte = mac_byte(src_mac, idx_r - REPLY_IDX_W'(22));
    end else if (idx_r inside {[28:31]}) begin
      reply_byte = ip_byte(cur_r.target_ip, idx_r - REPLY_IDX_W'(28));
    end else if (idx_r inside {[32:37]}) begin
      reply_byte = mac_byte(cur_r.sender_mac, idx_r - REPLY_IDX_W'(32));
    end else begin
      reply_byte = ip_byte(cur_r.sender_ip, idx_r - REPLY_IDX_W'(38));
    end
  end

  always_comb begin
    cur_nxt        = cur_r;
    active_nxt     = active_r;
    idx_nxt        = idx_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (emit) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {cur_r.frame_src_mac, reply_byte};
      out_tlast_nxt  = at_end;
      idx_nxt        = idx_r + REPLY_IDX_W'(1);
      if (at_end) begin
        active_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      cur_nxt    = q_desc;
      active_nxt = 1'b1;
      idx_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      idx_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      active_r     <= active_nxt;
      idx_r        <= idx_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (idx_r <= REPLY_IDX_W'(REPLY_LEN - 1)))
    else $error("reply byte index ran past the end of the reply");

  a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!active_r || at_end))
    else $error("descriptor taken while a reply was still in progress");

endmodule

@@ rtl/core/arp_request_responder_top.sv @@
// ----------------------------------------------------------------------------
// arp_request_responder_top
// ARP request responder for a virtual Ethernet/IPv4 subnet.
// ----------------------------------------------------------------------------
// Frame bytes are taken at one per clock. The parser decides on the frame's
// last byte, in the same cycle, whether it is an ARP request to an answered
// host, and if so queues a reply descriptor. The serializer sends each reply
// as 42 bytes, one per clock while out_tready allows, through a registered
// output, loading each descriptor into a current-reply register first; the
// next reply follows without a gap. A frame that earns a reply is at least
// 42 bytes long, so the output keeps up with the input while it is never held
// back. The input stalls only when the two-entry descriptor queue is full,
// which happens only under back-pressure on the output side.
// Configuration writes are registered and must be made while idle.
module arp_request_responder_top
  import arp_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // [7:0] reply_byte, [55:8] client_mac
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_t        cfg_r, cfg_nxt;
  logic        cfg_we;
  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_not_empty;
  reply_desc_t push_desc;
  reply_desc_t pop_desc;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_NET_ADDR:    cfg_nxt.net_addr         = cfg_data[31:0];
        CFG_NET_MASK:    cfg_nxt.net_mask         = cfg_data[31:0];
        CFG_DNS_HOST:    cfg_nxt.dns_host         = cfg_data[7:0];
        CFG_ALIAS_HOST:  cfg_nxt.alias_host       = cfg_data[7:0];
        CFG_SERVICE_MAP: cfg_nxt.service_host_map = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.net_addr         <= NET_ADDR_RST;
      cfg_r.net_mask         <= NET_MASK_RST;
      cfg_r.dns_host         <= DNS_HOST_RST;
      cfg_r.alias_host       <= ALIAS_HOST_RST;
      cfg_r.service_host_map <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  arp_front #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_desc    (push_desc)
  );

  arp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .pop_desc  (pop_desc),
    .not_empty (q_not_empty)
  );

  arp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_not_empty),
    .q_desc     (pop_desc),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
